/* rtl/alqs_pkg.sv */
`timescale 1ns / 1ps

package alqs_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // structure kinds, the unused code behaves as a stack
  localparam logic [1:0] KIND_LIST  = 2'd0;
  localparam logic [1:0] KIND_QUEUE = 2'd1;
  localparam logic [1:0] KIND_STACK = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [1:0] kind_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [3:0]         index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [4:0]         count;
  } rsp_t;

endpackage

/* rtl/alqs_chan_if.sv */
`timescale 1ns / 1ps

interface alqs_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/alqs_ram.sv */
`timescale 1ns / 1ps

module alqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/alqs_ctrl.sv */
`timescale 1ns / 1ps

module alqs_ctrl
  import alqs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kind_t                            structure_kind,
  alqs_chan_if.sink                        req,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rsp_t                             res,
  output logic                             mem_we,
  output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
  output logic [31:0]                      mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
  input  logic [31:0]                      mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUT,
    S_FIND_FWD,
    S_FIND_BWD,
    S_UP,
    S_UP_LAST,
    S_DN,
    S_DN_LAST,
    S_HEAD_RD,
    S_HEAD_CAP,
    S_RD_ISSUE,
    S_RD_CAP,
    S_DONE
  } state_t;

  state_t      state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ptr;
  logic [CW-1:0] lag;
  logic          lag_ok;
  logic [CW-1:0] pos;
  logic [31:0]   val_r;
  logic [1:0]    status_r;
  logic [31:0]   data_r;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   lag_up;
  logic [CW-1:0]   lag_dn;
  logic            full;
  logic [CW+3:0]   idx_w;
  logic [CW+3:0]   cnt_cmp;
  logic [CW+4:0]   cnt_w;

  assign cnt_m1  = cnt - CW'(1);
  assign lag_up  = lag + CW'(1);
  assign lag_dn  = lag - CW'(1);
  assign full    = (cnt == CW'(CAPACITY));
  assign idx_w   = {{CW{1'b0}}, req.data.index};
  assign cnt_cmp = {4'd0, cnt};
  assign cnt_w   = {5'd0, cnt};

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: status_r, data_out: data_r, count: cnt_w[4:0]};

  // one read issued per cycle at ptr, its data comes back from the registered RAM read tagged by lag
  assign mem_raddr = ptr[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lag_up[AW-1:0];
    mem_wdata = mem_rdata;
    unique case (state)
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = val_r;
      end
      S_UP, S_UP_LAST: begin
        mem_we    = lag_ok;
        mem_waddr = lag_up[AW-1:0];
      end
      S_DN, S_DN_LAST: begin
        mem_we    = lag_ok;
        mem_waddr = lag_dn[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      lag_ok <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            val_r    <= req.data.value;
            status_r <= ST_OK;
            data_r   <= '0;
            lag_ok   <= 1'b0;
            unique case (req.data.operation)
              OP_INSERT: begin
                if (full) begin
                  status_r <= ST_FULL;
                  state    <= S_DONE;
                end else if (structure_kind == KIND_QUEUE) begin
                  pos   <= cnt;
                  state <= S_PUT;
                end else if (cnt == '0) begin
                  pos   <= '0;
                  state <= S_PUT;
                end else if (structure_kind == KIND_LIST) begin
                  ptr   <= '0;
                  state <= S_FIND_FWD;
                end else begin
                  pos   <= '0;
                  ptr   <= cnt_m1;
                  state <= S_UP;
                end
              end
              OP_REMOVE: begin
                if (cnt == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_DONE;
                end else if (structure_kind == KIND_LIST) begin
                  ptr   <= cnt_m1;
                  state <= S_FIND_BWD;
                end else begin
                  ptr   <= '0;
                  state <= S_HEAD_RD;
                end
              end
              OP_CLEAR: begin
                cnt   <= '0;
                state <= S_DONE;
              end
              OP_READ: begin
                // slots at or past the fill count read as zero
                if (idx_w >= cnt_cmp) begin
                  state <= S_DONE;
                end else begin
                  ptr   <= idx_w[CW-1:0];
                  state <= S_RD_ISSUE;
                end
              end
            endcase
          end
        end
        S_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_FIND_FWD: begin
          // first slot not below the new value
          if (lag_ok && !($signed(val_r) > $signed(mem_rdata))) begin
            pos    <= lag;
            ptr    <= cnt_m1;
            lag_ok <= 1'b0;
            state  <= S_UP;
          end else if (lag_ok && lag == cnt_m1) begin
            pos   <= cnt;
            state <= S_PUT;
          end else begin
            lag    <= ptr;
            lag_ok <= 1'b1;
            ptr    <= ptr + CW'(1);
          end
        end
        S_UP: begin
          lag    <= ptr;
          lag_ok <= 1'b1;
          if (ptr == pos) begin
            state <= S_UP_LAST;
          end else begin
            ptr <= ptr - CW'(1);
          end
        end
        S_UP_LAST: begin
          state <= S_PUT;
        end
        S_FIND_BWD: begin
          // match nearest the tail wins
          if (lag_ok && mem_rdata == val_r) begin
            data_r <= val_r;
            if (lag == cnt_m1) begin
              cnt   <= cnt_m1;
              state <= S_DONE;
            end else begin
              ptr    <= lag_up;
              lag_ok <= 1'b0;
              state  <= S_DN;
            end
          end else if (lag_ok && lag == '0) begin
            status_r <= ST_NOTFOUND;
            state    <= S_DONE;
          end else begin
            lag    <= ptr;
            lag_ok <= 1'b1;
            ptr    <= ptr - CW'(1);
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD_CAP;
        end
        S_HEAD_CAP: begin
          data_r <= mem_rdata;
          if (cnt == CW'(1)) begin
            cnt   <= cnt_m1;
            state <= S_DONE;
          end else begin
            ptr    <= CW'(1);
            lag_ok <= 1'b0;
            state  <= S_DN;
          end
        end
        S_DN: begin
          lag    <= ptr;
          lag_ok <= 1'b1;
          if (ptr == cnt_m1) begin
            state <= S_DN_LAST;
          end else begin
            ptr <= ptr + CW'(1);
          end
        end
        S_DN_LAST: begin
          cnt   <= cnt_m1;
          state <= S_DONE;
        end
        S_RD_ISSUE: begin
          state <= S_RD_CAP;
        end
        S_RD_CAP: begin
          data_r <= mem_rdata;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/array_list_queue_stack.sv */
`timescale 1ns / 1ps

// Fixed-capacity store of signed 32-bit entries that works as a sorted list, a
// FIFO queue or a LIFO stack, picked by the kind register on the cfg channel
// (write it only while no operation is in flight). Each transfer on req is one
// operation (insert, remove, clear, read) and gives exactly one transfer on rsp
// with status, data_out and the entry count afterward. Entries live in one
// single-port-read, single-port-write RAM with a registered read, and every
// insert or remove that moves entries walks them one per cycle through that
// RAM, so the time an operation takes depends on the operation and, where
// entries move, on the fill count n: stack insert and head remove shift the
// entries, list insert does a forward scan for the position, then the shift
// up from the tail, and list remove does a backward scan for the match, then
// the shift down. No clearing pass is needed after reset or clear: slots
// past the fill count always read as zero. A finished result sits in an
// output register, so the next operation is taken while it waits on rsp.
module array_list_queue_stack
  import alqs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  alqs_chan_if.sink    req,
  alqs_chan_if.source  rsp,
  alqs_chan_if.sink    cfg
);

  localparam int AW = $clog2(CAPACITY);

  kind_t           structure_kind;
  logic            res_valid;
  logic            res_ready;
  rsp_t            res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [31:0]     mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      structure_kind <= KIND_LIST;
    end else if (cfg.valid) begin
      structure_kind <= cfg.data;
    end
  end

  // output register frees the sequencer while a result waits
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      rsp.data <= res;
    end
  end

  alqs_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .structure_kind (structure_kind),
    .req            (req),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  alqs_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/alqs_checker.sv */
`timescale 1ns / 1ps

module alqs_checker
  import alqs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("rsp changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count == 5'(CAPACITY))
    else $error("full reported below capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_EMPTY |->
      rsp_data.count == 5'd0 && rsp_data.data_out == 32'sd0)
    else $error("empty result with entries or data");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_NOTFOUND |-> rsp_data.data_out == 32'sd0)
    else $error("not-found result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 31) || (int'(rsp_data.count) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind array_list_queue_stack alqs_checker #(
  .CAPACITY (CAPACITY)
) u_alqs_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

/* verif/array_list_queue_stack_test.sv */
`timescale 1ns / 1ps

module array_list_queue_stack_test;
  import alqs_pkg::*;

  localparam int CAPACITY = 16;
  localparam int MAX_GAP = 12;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;
  // code 3 has no name in the package, the block treats it as a stack
  localparam kind_t KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;

  alqs_chan_if #(.T(req_t))  req_if ();
  alqs_chan_if #(.T(rsp_t))  rsp_if ();
  alqs_chan_if #(.T(kind_t)) cfg_if ();

  array_list_queue_stack #(.CAPACITY(CAPACITY)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // shadow copy of the store, updated at each accepted operation
  logic signed [31:0] shadow [CAPACITY];
  int                 shadow_fill;
  kind_t              shadow_kind;
  rsp_t               results_due [$];
  int                 mismatches;
  int                 send_quiet = 0;
  int                 recv_quiet = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // per-transfer wait, with occasional runs of back-to-back transfers
  function automatic int draw_gap(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic rsp_t apply_to_shadow(req_t r);
    rsp_t res;
    int   pos;
    res = '0;
    res.status = ST_OK;
    case (r.operation)
      OP_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (shadow_kind == KIND_QUEUE) begin
          shadow[shadow_fill] = r.value;
          shadow_fill++;
        end else begin
          pos = 0;
          // sorted: goes in front of the first entry not below it
          if (shadow_kind == KIND_LIST) begin
            while (pos < shadow_fill && r.value > shadow[pos]) pos++;
          end
          for (int i = shadow_fill; i > pos; i--) shadow[i] = shadow[i - 1];
          shadow[pos] = r.value;
          shadow_fill++;
        end
      end
      OP_REMOVE: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = -1;
          // list mode deletes the match nearest the tail
          if (shadow_kind == KIND_LIST) begin
            for (int i = shadow_fill - 1; i >= 0; i--) begin
              if (pos < 0 && shadow[i] == r.value) pos = i;
            end
          end else begin
            pos = 0;
          end
          if (pos < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.data_out = shadow[pos];
            for (int i = pos; i + 1 < shadow_fill; i++) shadow[i] = shadow[i + 1];
            shadow[shadow_fill - 1] = '0;
            shadow_fill--;
          end
        end
      end
      OP_CLEAR: begin
        foreach (shadow[i]) shadow[i] = '0;
        shadow_fill = 0;
      end
      default: begin
        res.data_out = shadow[r.index];
      end
    endcase
    res.count = 5'(shadow_fill);
    return res;
  endfunction

  task automatic send_op(logic [1:0] op, logic signed [31:0] val, logic [3:0] idx);
    req_t r;
    int   gap;
    r.operation = op;
    r.value = val;
    r.index = idx;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    results_due.push_back(apply_to_shadow(r));
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_kind(kind_t k);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= k;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    shadow_kind = k;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      // narrow range so that duplicates show up in list mode
      1, 2: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op(int insert_pct);
    int                 roll;
    logic [1:0]         op;
    logic signed [31:0] val;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) begin
      op = OP_INSERT;
    end else if (roll < 90) begin
      op = OP_REMOVE;
    end else if (roll < 99) begin
      op = OP_READ;
    end else begin
      op = OP_CLEAR;
    end
    if (op == OP_REMOVE && shadow_kind == KIND_LIST && shadow_fill > 0 &&
        $urandom_range(0, 3) != 0) begin
      val = shadow[$urandom_range(0, shadow_fill - 1)];
    end else begin
      val = pick_value();
    end
    send_op(op, val, 4'($urandom_range(0, CAPACITY - 1)));
  endtask

  task automatic test_empty_store();
    send_op(OP_READ, MOST_POS, 4'd0);
    send_op(OP_READ, MOST_NEG, 4'd15);
    send_op(OP_REMOVE, 32'sd0, 4'd0);
    send_op(OP_CLEAR, -32'sd1, 4'd15);
  endtask

  task automatic test_sorted_list();
    send_op(OP_INSERT, MOST_POS, 4'd0);
    send_op(OP_INSERT, MOST_NEG, 4'd0);
    send_op(OP_INSERT, -32'sd1, 4'd0);
    send_op(OP_INSERT, 32'sd0, 4'd0);
    send_op(OP_INSERT, -32'sd1, 4'd0);
    send_op(OP_READ, 32'sd0, 4'd0);
    send_op(OP_READ, 32'sd0, 4'd15);
    send_op(OP_REMOVE, 32'sd12345, 4'd0);
    send_op(OP_REMOVE, -32'sd1, 4'd0);
    send_op(OP_REMOVE, MOST_POS, 4'd0);
  endtask

  task automatic test_capacity();
    write_kind(KIND_QUEUE);
    send_op(OP_CLEAR, 32'sd0, 4'd0);
    repeat (CAPACITY) send_op(OP_INSERT, $urandom, 4'd0);
    send_op(OP_INSERT, MOST_NEG, 4'd0);
    send_op(OP_REMOVE, 32'sd0, 4'd0);
  endtask

  task automatic test_stack_kinds();
    // stack ops on top of what the queue left behind
    write_kind(KIND_STACK);
    send_op(OP_INSERT, 32'sd77, 4'd0);
    send_op(OP_REMOVE, 32'sd0, 4'd0);
    send_op(OP_READ, 32'sd0, 4'd14);
    write_kind(KIND_UNUSED);
    send_op(OP_INSERT, MOST_NEG, 4'd0);
    send_op(OP_REMOVE, 32'sd0, 4'd0);
  endtask

  task automatic test_random_mix(int items);
    kind_t kind_order [4];
    kind_t k;
    kind_order = '{KIND_LIST, KIND_QUEUE, KIND_STACK, KIND_UNUSED};
    for (int p = 0; p < 10; p++) begin
      k = (p < 4) ? kind_order[p] : kind_order[$urandom_range(0, 3)];
      write_kind(k);
      // alternate filling and draining phases so full and empty both occur
      repeat (items / 10) random_op((p % 2 == 0) ? 70 : 35);
    end
  endtask

  // result side: random stalls, compare every transfer with the oldest prediction
  initial begin
    int   stall;
    rsp_t want;
    @(posedge clk);
    forever begin
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d data_out %0d count %0d", $time,
                 rsp_if.data.status, rsp_if.data.data_out, rsp_if.data.count);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (rsp_if.data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, rsp_if.data.status);
          mismatches++;
        end
        if (rsp_if.data.data_out !== want.data_out) begin
          $display("%0t: data_out expected %0d actual %0d", $time,
                   want.data_out, rsp_if.data.data_out);
          mismatches++;
        end
        if (rsp_if.data.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time,
                   want.count, rsp_if.data.count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rsp_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    foreach (shadow[i]) shadow[i] = '0;
    shadow_fill = 0;
    shadow_kind = KIND_LIST;
    mismatches = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_sorted_list();
    test_capacity();
    test_stack_kinds();
    test_random_mix(1000);

    settle();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
